>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/isec_pkg.sv
// Shared types, widths and constants of the IMU swing event classifier.
package isec_pkg;

  localparam int AXIS_W     = 16;
  localparam int TIME_W     = 32;
  localparam int MAG_W      = 17;
  localparam int LEVEL_W    = 17;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MIN_SWING_MS_DEF = 200;
  localparam int COOLDOWN_MS_DEF  = 400;

  localparam logic [LEVEL_W-1:0] START_LEVEL_RST = 17'd25052;
  localparam logic [LEVEL_W-1:0] END_LEVEL_RST   = 17'd11691;

  localparam logic signed [18:0] GRAV_COEF = 19'sd3277;

  localparam logic [MAG_W-1:0] MAG_LIMIT     = 17'd113511;
  localparam logic [MAG_W-1:0] SPEED_STRONG  = 17'd55130;
  localparam logic [MAG_W-1:0] SPEED_MEDIUM  = 17'd48034;
  localparam logic [MAG_W-1:0] IMPACT_STRONG = 17'd70146;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_X_OFF = 3'd0,
    REG_ACCEL_Y_OFF = 3'd1,
    REG_ACCEL_Z_OFF = 3'd2,
    REG_GYRO_X_OFF  = 3'd3,
    REG_GYRO_Y_OFF  = 3'd4,
    REG_GYRO_Z_OFF  = 3'd5,
    REG_START_LEVEL = 3'd6,
    REG_END_LEVEL   = 3'd7
  } cfg_reg_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_WEAK   = 2'd0,
    CLASS_MEDIUM = 2'd1,
    CLASS_STRONG = 2'd2
  } swing_class_t;

endpackage

>>> rtl/isec_sample_if.sv
// Sample channel: one six-axis IMU sample with its timestamp.
interface isec_sample_if import isec_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;
  logic signed [AXIS_W-1:0] gyro_x;
  logic signed [AXIS_W-1:0] gyro_y;
  logic signed [AXIS_W-1:0] gyro_z;
  logic [TIME_W-1:0]        time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  time_ms, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                time_ms, output ready);
endinterface

>>> rtl/isec_result_if.sv
// Result channel: one finished swing event.
interface isec_result_if import isec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  end_time_ms;
  logic [MAG_W-1:0]   peak_speed;
  logic [MAG_W-1:0]   peak_impact;
  logic [TIME_W-1:0]  duration_ms;
  logic [CLASS_W-1:0] swing_class;

  modport source (output valid, end_time_ms, peak_speed, peak_impact, duration_ms,
                  swing_class, input ready);
  modport sink (input valid, end_time_ms, peak_speed, peak_impact, duration_ms,
                swing_class, output ready);
endinterface

>>> rtl/isec_cfg_if.sv
// Configuration write channel: register index and write data.
interface isec_cfg_if import isec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/imu_swing_event_classifier.sv
// IMU swing event classifier: offsets, gravity filter, magnitudes and swing tracking.
//
//  channel  | role | moves per transaction
//  ---------+------+------------------------------------------------
//  sample   | sink | six raw axes and time_ms
//  result   | src  | end time, peaks, duration and class of a swing
//  cfg      | sink | register index and data, ready always high
//
// Samples are taken one at a time: capture, gravity multiply, gravity update,
// linear Z, six squares on the shared multiplier, then two 36-bit square
// roots on the shared root unit at three result bits a cycle.
// The final cycle waits only while an earlier result has not been taken.
// rst is synchronous, clears offsets, swing state and gravity, and loads the default levels.
module imu_swing_event_classifier
  import isec_pkg::*;
#(
  parameter int MIN_SWING_MS = MIN_SWING_MS_DEF,
  parameter int COOLDOWN_MS  = COOLDOWN_MS_DEF
) (
  input logic           clk,
  input logic           rst,
  isec_sample_if.sink   sample,
  isec_result_if.source result,
  isec_cfg_if.sink      cfg
);

  localparam logic [TIME_W-1:0] MIN_SWING = TIME_W'(MIN_SWING_MS);
  localparam logic [TIME_W-1:0] COOLDOWN  = TIME_W'(COOLDOWN_MS);

  typedef enum logic [2:0] {
    S_IDLE, S_GMUL, S_GUPD, S_LZ, S_SQR, S_ROOT, S_DEC
  } state_t;

  state_t state;

  logic signed [AXIS_W-1:0]  off [6];
  logic [LEVEL_W-1:0]        start_level;
  logic [LEVEL_W-1:0]        end_level;

  logic signed [AXIS_W:0]    ax, ay, az, gx, gy, gz;
  logic [TIME_W-1:0]         now;
  logic signed [33:0]        grav;
  logic signed [54:0]        prod;
  logic signed [18:0]        lz;
  logic [2:0]                sq_idx;
  logic [35:0]               acc_sum;
  logic [33:0]               spd_sum;
  logic [35:0]               rad;
  logic [19:0]               rem;
  logic [17:0]               root;
  logic [2:0]                root_cnt;
  logic                      root_sel;
  logic [MAG_W-1:0]          acc_mag;
  logic [MAG_W-1:0]          spd_mag;

  logic                      active;
  logic [TIME_W-1:0]         start_time;
  logic [TIME_W-1:0]         last_end;
  logic [MAG_W-1:0]          speed_peak;
  logic [MAG_W-1:0]          impact_peak;

  logic                      res_valid;
  logic [TIME_W-1:0]         res_end_time;
  logic [MAG_W-1:0]          res_speed;
  logic [MAG_W-1:0]          res_impact;
  logic [TIME_W-1:0]         res_duration;
  swing_class_t              res_class;

  // Shared multiplier
  logic signed [35:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [54:0] mul_p;
  logic signed [35:0] target_x;
  logic signed [35:0] grav_x;
  logic signed [18:0] sq_op;
  logic signed [35:0] lz_full;

  assign target_x = {{3{az[AXIS_W]}}, az, 16'b0};
  assign grav_x   = {{2{grav[33]}}, grav};
  assign lz_full  = target_x - grav_x + 36'sd32768;

  always_comb begin
    case (sq_idx)
      3'd0:    sq_op = {{2{ax[AXIS_W]}}, ax};
      3'd1:    sq_op = {{2{ay[AXIS_W]}}, ay};
      3'd2:    sq_op = lz;
      3'd3:    sq_op = {{2{gx[AXIS_W]}}, gx};
      3'd4:    sq_op = {{2{gy[AXIS_W]}}, gy};
      default: sq_op = {{2{gz[AXIS_W]}}, gz};
    endcase
    if (state == S_GMUL) begin
      mul_a = target_x - grav_x;
      mul_b = GRAV_COEF;
    end else begin
      mul_a = {{17{sq_op[18]}}, sq_op};
      mul_b = sq_op;
    end
    mul_p = mul_a * mul_b;
  end

  // Shared root unit: three result bits a cycle
  logic [19:0] rem_next;
  logic [17:0] root_next;
  logic [35:0] rad_next;
  logic [21:0] r_w;
  logic [21:0] t_w;

  always_comb begin
    rem_next  = rem;
    root_next = root;
    rad_next  = rad;
    for (int j = 0; j < 3; j++) begin
      r_w = {rem_next, rad_next[35:34]};
      t_w = {2'b0, root_next, 2'b01};
      if (r_w >= t_w) begin
        rem_next  = 20'(r_w - t_w);
        root_next = {root_next[16:0], 1'b1};
      end else begin
        rem_next  = r_w[19:0];
        root_next = {root_next[16:0], 1'b0};
      end
      rad_next = {rad_next[33:0], 2'b00};
    end
  end

  logic [MAG_W-1:0] acc_root_sat;
  assign acc_root_sat = (root_next > {1'b0, MAG_LIMIT}) ? MAG_LIMIT : root_next[MAG_W-1:0];

  // Swing decision
  logic              start_hit;
  logic              act1;
  logic [MAG_W-1:0]  sp1, ip1, sp2, ip2;
  logic [TIME_W-1:0] st1;
  logic [TIME_W-1:0] dur;
  logic              emit;
  logic              stall;
  swing_class_t      cls;

  always_comb begin
    start_hit = !active && (acc_mag > start_level) && ((now - last_end) > COOLDOWN);
    act1 = active || start_hit;
    sp1  = start_hit ? spd_mag : speed_peak;
    ip1  = start_hit ? acc_mag : impact_peak;
    st1  = start_hit ? now : start_time;
    sp2  = (spd_mag > sp1) ? spd_mag : sp1;
    ip2  = (acc_mag > ip1) ? acc_mag : ip1;
    dur  = now - st1;
    emit = act1 && (acc_mag < end_level) && (dur > MIN_SWING);
    if (sp2 >= SPEED_STRONG && ip2 >= IMPACT_STRONG) begin
      cls = CLASS_STRONG;
    end else if (sp2 >= SPEED_MEDIUM) begin
      cls = CLASS_MEDIUM;
    end else begin
      cls = CLASS_WEAK;
    end
    stall = emit && res_valid && !result.ready;
  end

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid       = res_valid;
  assign result.end_time_ms = res_end_time;
  assign result.peak_speed  = res_speed;
  assign result.peak_impact = res_impact;
  assign result.duration_ms = res_duration;
  assign result.swing_class = res_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        off[i] <= '0;
      end
      start_level <= START_LEVEL_RST;
      end_level   <= END_LEVEL_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ACCEL_X_OFF, REG_ACCEL_Y_OFF, REG_ACCEL_Z_OFF,
        REG_GYRO_X_OFF, REG_GYRO_Y_OFF, REG_GYRO_Z_OFF: begin
          off[cfg.index] <= cfg.data[AXIS_W-1:0];
        end
        REG_START_LEVEL: start_level <= cfg.data;
        REG_END_LEVEL:   end_level   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grav        <= '0;
      active      <= 1'b0;
      start_time  <= '0;
      last_end    <= '0;
      speed_peak  <= '0;
      impact_peak <= '0;
      res_valid   <= 1'b0;
      sq_idx      <= '0;
      root_cnt    <= '0;
      root_sel    <= 1'b0;
    end else begin
      if (state == S_DEC && emit && !stall) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ax  <= {sample.accel_x[AXIS_W-1], sample.accel_x} - {off[0][AXIS_W-1], off[0]};
            ay  <= {sample.accel_y[AXIS_W-1], sample.accel_y} - {off[1][AXIS_W-1], off[1]};
            az  <= {sample.accel_z[AXIS_W-1], sample.accel_z} - {off[2][AXIS_W-1], off[2]};
            gx  <= {sample.gyro_x[AXIS_W-1], sample.gyro_x} - {off[3][AXIS_W-1], off[3]};
            gy  <= {sample.gyro_y[AXIS_W-1], sample.gyro_y} - {off[4][AXIS_W-1], off[4]};
            gz  <= {sample.gyro_z[AXIS_W-1], sample.gyro_z} - {off[5][AXIS_W-1], off[5]};
            now <= sample.time_ms;
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          prod  <= mul_p;
          state <= S_GUPD;
        end
        S_GUPD: begin
          grav  <= grav + prod[49:16];
          state <= S_LZ;
        end
        S_LZ: begin
          lz      <= lz_full[34:16];
          acc_sum <= '0;
          spd_sum <= '0;
          sq_idx  <= '0;
          state   <= S_SQR;
        end
        S_SQR: begin
          if (sq_idx < 3'd3) begin
            acc_sum <= acc_sum + mul_p[35:0];
          end else begin
            spd_sum <= spd_sum + mul_p[33:0];
          end
          if (sq_idx == 3'd5) begin
            rad      <= (sq_idx < 3'd3) ? acc_sum : acc_sum;
            rem      <= '0;
            root     <= '0;
            root_cnt <= '0;
            root_sel <= 1'b0;
            state    <= S_ROOT;
          end else begin
            sq_idx <= sq_idx + 3'd1;
          end
        end
        S_ROOT: begin
          if (root_cnt == 3'd5) begin
            rem      <= '0;
            root     <= '0;
            root_cnt <= '0;
            if (!root_sel) begin
              acc_mag  <= acc_root_sat;
              rad      <= {2'b00, spd_sum};
              root_sel <= 1'b1;
            end else begin
              spd_mag <= root_next[MAG_W-1:0];
              state   <= S_DEC;
            end
          end else begin
            rem      <= rem_next;
            root     <= root_next;
            rad      <= rad_next;
            root_cnt <= root_cnt + 3'd1;
          end
        end
        S_DEC: begin
          if (!stall) begin
            if (act1) begin
              speed_peak  <= sp2;
              impact_peak <= ip2;
              start_time  <= st1;
            end
            active <= act1 && !emit;
            if (emit) begin
              last_end     <= now;
              res_end_time <= now;
              res_speed    <= sp2;
              res_impact   <= ip2;
              res_duration <= dur;
              res_class    <= cls;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/isec_checker.sv
// Port-level checker for the swing classifier and its bind.
`include "assert_macros.svh"

module isec_checker
  import isec_pkg::*;
#(
  parameter int MIN_SWING_MS = MIN_SWING_MS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               s_valid,
  input logic               s_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic [MAG_W-1:0]   r_speed,
  input logic [MAG_W-1:0]   r_impact,
  input logic [TIME_W-1:0]  r_duration,
  input logic [CLASS_W-1:0] r_class
);

  localparam logic [TIME_W-1:0] MIN_SWING = TIME_W'(MIN_SWING_MS);

  `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "sample taken while busy")
  `ASSERT_NEXT(a_result_held, r_valid && !r_ready, r_valid && $stable(r_duration) && $stable(r_class), "result dropped or changed while stalled")
  `ASSERT_IMPLIES(a_strong_peaks, r_valid && r_class == CLASS_STRONG, r_speed >= SPEED_STRONG && r_impact >= IMPACT_STRONG, "strong class below limits")
  `ASSERT_IMPLIES(a_result_bounds, r_valid, r_duration > MIN_SWING && r_impact <= MAG_LIMIT && r_speed <= MAG_LIMIT, "result out of range")

endmodule

bind imu_swing_event_classifier isec_checker #(
  .MIN_SWING_MS(MIN_SWING_MS)
) u_isec_checker (
  .clk        (clk),
  .rst        (rst),
  .s_valid    (sample.valid),
  .s_ready    (sample.ready),
  .r_valid    (result.valid),
  .r_ready    (result.ready),
  .r_speed    (result.peak_speed),
  .r_impact   (result.peak_impact),
  .r_duration (result.duration_ms),
  .r_class    (result.swing_class)
);

>>> sim/tb.sv
// Self-checking bench for the IMU swing event classifier: directed and random samples.
module tb;
  import isec_pkg::*;

  localparam int MIN_SWING   = MIN_SWING_MS_DEF;
  localparam int COOLDOWN    = COOLDOWN_MS_DEF;
  localparam int SETTLE_CYC  = 60;
  localparam int HOLD_CYC    = 3000;
  localparam int STALL_LIMIT = 30000;
  localparam int REPORT_MAX  = 10;
  localparam int ONE_G       = 16384;

  typedef struct {
    logic signed [AXIS_W-1:0] ax, ay, az, gx, gy, gz;
    logic [TIME_W-1:0]        stamp;
  } imu_sample_t;

  typedef struct {
    logic [TIME_W-1:0] end_ms;
    logic [MAG_W-1:0]  speed;
    logic [MAG_W-1:0]  impact;
    logic [TIME_W-1:0] dur_ms;
    swing_class_t      cls;
  } swing_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isec_sample_if smp ();
  isec_result_if res ();
  isec_cfg_if    cfg_ch ();

  imu_swing_event_classifier #(.MIN_SWING_MS(MIN_SWING), .COOLDOWN_MS(COOLDOWN)) dut (
    .clk(clk), .rst(rst), .sample(smp), .result(res), .cfg(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [AXIS_W-1:0] m_off [6];
  logic [LEVEL_W-1:0]       m_start_lvl, m_end_lvl;
  logic                     m_active;
  logic [TIME_W-1:0]        m_start_ms, m_last_end_ms;
  logic [MAG_W-1:0]         m_speed_pk, m_impact_pk;
  longint                   m_grav;

  // stimulus side
  logic signed [AXIS_W-1:0] plan_off [6] = '{default: '0};
  imu_sample_t              samples_to_send [$];
  swing_event_t             swings_due [$];
  int                       samples_queued = 0;
  int                       samples_taken = 0;
  int                       mismatches = 0;
  int                       src_idle_pct = 32;
  int                       snk_idle_pct = 65;
  int                       phase_no = 0;
  int                       stall_cycles = 0;
  logic [TIME_W-1:0]        clock_ms = '0;
  logic                     hold_rx = 1'b0;

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return longint'(root);
  endfunction

  task automatic track_swing(input imu_sample_t s, output bit done, output swing_event_t ev);
    longint ax, ay, az, gx, gy, gz, target, lz, acc, spd;
    logic [TIME_W-1:0] dur;
    ax = longint'(s.ax) - longint'(m_off[REG_ACCEL_X_OFF]);
    ay = longint'(s.ay) - longint'(m_off[REG_ACCEL_Y_OFF]);
    az = longint'(s.az) - longint'(m_off[REG_ACCEL_Z_OFF]);
    gx = longint'(s.gx) - longint'(m_off[REG_GYRO_X_OFF]);
    gy = longint'(s.gy) - longint'(m_off[REG_GYRO_Y_OFF]);
    gz = longint'(s.gz) - longint'(m_off[REG_GYRO_Z_OFF]);
    target = az * 65536;
    m_grav += ((target - m_grav) * longint'(GRAV_COEF)) >>> 16;
    lz = (target - m_grav + 32768) >>> 16;
    acc = floor_sqrt(ax * ax + ay * ay + lz * lz);
    if (acc > longint'(MAG_LIMIT)) acc = longint'(MAG_LIMIT);
    spd = floor_sqrt(gx * gx + gy * gy + gz * gz);
    done = 1'b0;
    if (!m_active && acc > longint'(m_start_lvl) &&
        (s.stamp - m_last_end_ms) > 32'(COOLDOWN)) begin
      m_active = 1'b1;
      m_start_ms = s.stamp;
      m_speed_pk = spd[MAG_W-1:0];
      m_impact_pk = acc[MAG_W-1:0];
    end
    if (m_active) begin
      if (spd > longint'(m_speed_pk)) m_speed_pk = spd[MAG_W-1:0];
      if (acc > longint'(m_impact_pk)) m_impact_pk = acc[MAG_W-1:0];
      dur = s.stamp - m_start_ms;
      if (acc < longint'(m_end_lvl) && dur > 32'(MIN_SWING)) begin
        ev.end_ms = s.stamp;
        ev.speed = m_speed_pk;
        ev.impact = m_impact_pk;
        ev.dur_ms = dur;
        if (m_speed_pk >= SPEED_STRONG && m_impact_pk >= IMPACT_STRONG) ev.cls = CLASS_STRONG;
        else if (m_speed_pk >= SPEED_MEDIUM) ev.cls = CLASS_MEDIUM;
        else ev.cls = CLASS_WEAK;
        m_active = 1'b0;
        m_last_end_ms = s.stamp;
        done = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch_ports
    imu_sample_t  s;
    swing_event_t want, got;
    bit           done;
    if (rst) begin
      foreach (m_off[i]) m_off[i] = '0;
      m_start_lvl = START_LEVEL_RST;
      m_end_lvl = END_LEVEL_RST;
      m_active = 1'b0;
      m_start_ms = '0;
      m_last_end_ms = '0;
      m_speed_pk = '0;
      m_impact_pk = '0;
      m_grav = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_START_LEVEL: m_start_lvl = cfg_ch.data[LEVEL_W-1:0];
          REG_END_LEVEL:   m_end_lvl = cfg_ch.data[LEVEL_W-1:0];
          default:         m_off[cfg_ch.index] = cfg_ch.data[AXIS_W-1:0];
        endcase
      end
      if (res.valid && res.ready) begin
        got.end_ms = res.end_time_ms;
        got.speed = res.peak_speed;
        got.impact = res.peak_impact;
        got.dur_ms = res.duration_ms;
        got.cls = swing_class_t'(res.swing_class);
        if (swings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected swing result at %0t: end %0d", $time, got.end_ms);
        end else begin
          want = swings_due.pop_front();
          if (got.end_ms !== want.end_ms || got.speed !== want.speed ||
              got.impact !== want.impact || got.dur_ms !== want.dur_ms ||
              got.cls !== want.cls) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"swing mismatch at %0t (expected/actual): end %0d/%0d ",
                        "speed %0d/%0d impact %0d/%0d dur %0d/%0d class %0d/%0d"},
                       $time, want.end_ms, got.end_ms, want.speed, got.speed,
                       want.impact, got.impact, want.dur_ms, got.dur_ms, want.cls, got.cls);
          end
        end
      end
      if (smp.valid && smp.ready) begin
        s.ax = smp.accel_x;
        s.ay = smp.accel_y;
        s.az = smp.accel_z;
        s.gx = smp.gyro_x;
        s.gy = smp.gyro_y;
        s.gz = smp.gyro_z;
        s.stamp = smp.time_ms;
        samples_taken++;
        track_swing(s, done, want);
        if (done) swings_due.push_back(want);
      end
    end
  end

  always @(posedge clk) begin : send_samples
    imu_sample_t s;
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (!smp.valid || smp.ready) begin
      if (samples_to_send.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        s = samples_to_send.pop_front();
        smp.valid <= 1'b1;
        smp.accel_x <= s.ax;
        smp.accel_y <= s.ay;
        smp.accel_z <= s.az;
        smp.gyro_x <= s.gx;
        smp.gyro_y <= s.gy;
        smp.gyro_z <= s.gz;
        smp.time_ms <= s.stamp;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= !hold_rx && ($urandom_range(99, 0) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold off the result side so the block fills and stalls its input
  initial begin : rx_hold
    wait (phase_no == 4);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_rx <= 1'b0;
  end

  function automatic logic signed [AXIS_W-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return AXIS_W'(v);
  endfunction

  function automatic longint spread(input int amp);
    return longint'($urandom_range(2 * amp, 0)) - amp;
  endfunction

  task automatic queue_sample(input longint ax, ay, az, gx, gy, gz,
                              input logic [TIME_W-1:0] stamp);
    imu_sample_t s;
    s.ax = clip16(ax);
    s.ay = clip16(ay);
    s.az = clip16(az);
    s.gx = clip16(gx);
    s.gy = clip16(gy);
    s.gz = clip16(gz);
    s.stamp = stamp;
    samples_to_send.push_back(s);
    samples_queued++;
    clock_ms = stamp;
  endtask

  task automatic queue_quiet(input longint grav_raw, input int dt);
    queue_sample(plan_off[0] + spread(1500), plan_off[1] + spread(1500),
                 plan_off[2] + grav_raw + spread(1500), plan_off[3] + spread(3000),
                 plan_off[4] + spread(3000), plan_off[5] + spread(3000), clock_ms + dt);
  endtask

  // quiet lead-in, a burst of motion, then a quiet tail
  task automatic queue_swing();
    int     n_pre, n_burst, n_post, amp_a, amp_g;
    longint grav_raw, az, gyro [3];
    bit     wild_gyro, flip_z;
    case ($urandom_range(2, 0))
      0:       grav_raw = ONE_G;
      1:       grav_raw = 32767;
      default: grav_raw = -32768;
    endcase
    amp_a = ($urandom_range(2, 0) == 0) ? 8000 : (($urandom_range(1, 0) != 0) ? 20000 : 32767);
    amp_g = ($urandom_range(1, 0) != 0) ? 20000 : 32767;
    wild_gyro = ($urandom_range(2, 0) == 0);
    flip_z = ($urandom_range(1, 0) != 0);
    n_pre = $urandom_range(6, 2);
    n_burst = $urandom_range(25, 3);
    n_post = $urandom_range(25, 3);
    for (int i = 0; i < n_pre; i++)
      queue_quiet(grav_raw, (i == n_pre - 1) ? $urandom_range(700, 300) : 10);
    for (int i = 0; i < n_burst; i++) begin
      az = (i == 0 && flip_z) ? -grav_raw : spread(amp_a);
      foreach (gyro[k])
        gyro[k] = wild_gyro ? (($urandom_range(1, 0) != 0) ? 32767 : -32768) : spread(amp_g);
      queue_sample(spread(amp_a), spread(amp_a), az, gyro[0], gyro[1], gyro[2],
                   clock_ms + $urandom_range(20, 5));
    end
    for (int i = 0; i < n_post; i++) queue_quiet(grav_raw, 10);
  endtask

  task automatic queue_noise();
    int                n;
    logic [TIME_W-1:0] stamp;
    n = $urandom_range(5, 1);
    for (int i = 0; i < n; i++) begin
      stamp = ($urandom_range(9, 0) == 0) ? $urandom() : clock_ms + $urandom_range(2000, 0);
      queue_sample(spread(32768), spread(32768), spread(32768), spread(32768),
                   spread(32768), spread(32768), stamp);
    end
  endtask

  task automatic queue_mix(input int count);
    int goal;
    goal = samples_queued + count;
    while (samples_queued < goal) begin
      if ($urandom_range(99, 0) < 85) queue_swing();
      else queue_noise();
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input longint val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx <= REG_GYRO_Z_OFF) plan_off[idx] = AXIS_W'(val);
  endtask

  task automatic drain();
    while (samples_taken != samples_queued || swings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic start_phase(input int num, input int src_pct, input int snk_pct);
    @(negedge clk);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    phase_no = num;
  endtask

  initial begin : run_phases
    smp.valid = 1'b0;
    smp.accel_x = '0;
    smp.accel_y = '0;
    smp.accel_z = '0;
    smp.gyro_x = '0;
    smp.gyro_y = '0;
    smp.gyro_z = '0;
    smp.time_ms = '0;
    res.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: cooldown from time zero, strict thresholds, timestamp wrap
    start_phase(0, 32, 65);
    queue_sample(0, 0, 0, 0, 0, 0, 0);
    queue_sample(32767, 0, 0, 32767, 32767, 32767, 100);
    queue_sample(-32768, 0, 0, -32768, -32768, -32768, 400);
    queue_sample(-32768, -32768, 0, 32767, -32768, 32767, 401);
    queue_sample(20000, 0, 0, 100, 0, 0, 500);
    queue_sample(0, 0, 0, 0, 0, 0, 601);
    queue_sample(0, 0, 0, 0, 0, 0, 602);
    queue_sample(30000, 0, 0, 0, 0, 0, 1002);
    queue_sample(25052, 0, 0, 0, 0, 0, 1003);
    queue_sample(25053, 0, 0, 1000, 0, 0, 1004);
    queue_sample(11691, 0, 0, 0, 0, 0, 1300);
    queue_sample(11690, 0, 0, 0, 0, 0, 1301);
    queue_sample(32767, 32767, -32768, 32767, 32767, 32767, 32'hffff_ff00);
    queue_sample(0, 0, 0, 0, 0, 0, 32'h0000_0010);
    queue_mix(480);

    // extreme offsets, start level 0 and end level 131071
    drain();
    write_reg(REG_ACCEL_X_OFF, 32767);
    write_reg(REG_ACCEL_Y_OFF, -32768);
    write_reg(REG_ACCEL_Z_OFF, -32768);
    write_reg(REG_GYRO_X_OFF, -32768);
    write_reg(REG_GYRO_Y_OFF, 32767);
    write_reg(REG_GYRO_Z_OFF, -32768);
    write_reg(REG_START_LEVEL, 0);
    write_reg(REG_END_LEVEL, 131071);
    start_phase(1, 32, 65);
    queue_mix(100);
    // drive gravity high for the saturation step
    for (int i = 0; i < 60; i++)
      queue_sample(spread(32768), spread(32768), 32767, spread(32768), spread(32768),
                   spread(32768), clock_ms + 10);

    // flip the Z offset: magnitude saturates, swing never closes
    drain();
    write_reg(REG_ACCEL_Z_OFF, 32767);
    write_reg(REG_START_LEVEL, 113510);
    write_reg(REG_END_LEVEL, 0);
    start_phase(2, 32, 65);
    for (int i = 0; i < 4; i++)
      queue_sample(-32768, 32767, -32768, 32767, -32768, 32767, clock_ms + 10);
    queue_mix(60);

    drain();
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), spread(1000));
    write_reg(REG_START_LEVEL, $urandom_range(30000, 20000));
    write_reg(REG_END_LEVEL, $urandom_range(14000, 8000));
    start_phase(3, 65, 32);
    queue_mix(430);

    drain();
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), 0);
    write_reg(REG_START_LEVEL, START_LEVEL_RST);
    write_reg(REG_END_LEVEL, END_LEVEL_RST);
    start_phase(4, 0, 0);
    queue_mix(430);

    drain();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/isec_pkg.sv
rtl/isec_sample_if.sv
rtl/isec_result_if.sv
rtl/isec_cfg_if.sv
rtl/imu_swing_event_classifier.sv
rtl/isec_checker.sv
sim/tb.sv
